>>> design/lbbm_pkg.sv
// Shared types and constants for the LRU block buffer manager.
// Holds the beat structs, action and result codes, the controller states and the cell commands.
// Depends on nothing; the design files refer to it by scoped names and the testbench files import it.
`timescale 1ns / 1ps

package lbbm_pkg;

  // Tag value that marks a buffer as holding no block.
  localparam logic [31:0] UNASSIGNED_TAG = 32'hFFFF_FFFF;

  // Request codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_GET_READ    = 3'd0,
    ACT_GET_NO_READ = 3'd1,
    ACT_MARK_DIRTY  = 3'd2,
    ACT_SAVE_ALL    = 3'd3,
    ACT_FLUSH       = 3'd4,
    ACT_EMPTY       = 3'd5
  } action_t;

  // Result codes carried in the kind field.
  typedef enum logic [1:0] {
    KIND_ASSIGNED   = 2'd0,
    KIND_WRITE_BACK = 2'd1,
    KIND_DONE       = 2'd2,
    KIND_ERROR      = 2'd3
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GET_FIN,
    ST_SWEEP
  } state_t;

  // Commands broadcast to the row of buffer cells.
  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_ASSIGN,
    CELL_CLEAN,
    CELL_MARK,
    CELL_UNASSIGN,
    CELL_RESET
  } cell_op_t;

  typedef struct packed {
    cell_op_t    op;
    logic        write_tag;
    logic [31:0] blk;
  } cell_cmd_t;

  // Input beat.
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] block_number;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  buffer_index;
    logic [31:0] block_of_buffer;
    logic        hit;
    logic        fill_request;
    logic        last;
  } out_item_t;

endpackage

>>> design/lbbm_cell.sv
// One cell of the buffer row: the tag and dirty flag of one buffer, plus one slot of the
// recency list that shifts from its lower neighbour on a move to front.
// Depends on lbbm_pkg.
`timescale 1ns / 1ps

module lbbm_cell #(
  parameter int IDX_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    pos,
  input  lbbm_pkg::cell_cmd_t cmd,
  input  logic [IDX_W-1:0]    sel,
  input  logic [IDX_W-1:0]    prev_rec,
  input  logic                shift_in,
  output logic [31:0]         tag,
  output logic                dirty,
  output logic [IDX_W-1:0]    rec,
  output logic                shift_out
);

  logic [31:0]      tag_r, tag_nxt;
  logic             dirty_r, dirty_nxt;
  logic [IDX_W-1:0] rec_r, rec_nxt;
  logic             own;

  // The selected buffer is at this slot or further back: this slot shifts on a move to front.
  assign shift_out = shift_in | (rec_r == sel);
  assign own       = (pos == sel);

  // Next state of the cell for the broadcast command.
  always_comb begin
    tag_nxt   = tag_r;
    dirty_nxt = dirty_r;
    rec_nxt   = rec_r;
    case (cmd.op)
      lbbm_pkg::CELL_ASSIGN: begin
        if (own && cmd.write_tag) begin
          tag_nxt = cmd.blk;
        end
        if (shift_out) begin
          rec_nxt = prev_rec;
        end
      end
      lbbm_pkg::CELL_CLEAN: begin
        if (own) begin
          dirty_nxt = 1'b0;
        end
      end
      lbbm_pkg::CELL_MARK: begin
        if (own) begin
          dirty_nxt = 1'b1;
        end
      end
      lbbm_pkg::CELL_UNASSIGN: begin
        tag_nxt = lbbm_pkg::UNASSIGNED_TAG;
      end
      lbbm_pkg::CELL_RESET: begin
        tag_nxt   = lbbm_pkg::UNASSIGNED_TAG;
        dirty_nxt = 1'b0;
        rec_nxt   = pos;
      end
      default: begin
      end
    endcase
  end

  // Cell registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= lbbm_pkg::UNASSIGNED_TAG;
      dirty_r <= 1'b0;
      rec_r   <= pos;
    end else begin
      tag_r   <= tag_nxt;
      dirty_r <= dirty_nxt;
      rec_r   <= rec_nxt;
    end
  end

  assign tag   = tag_r;
  assign dirty = dirty_r;
  assign rec   = rec_r;

endmodule

>>> design/lru_block_buffer_manager_unit.sv
// Top level of the LRU block buffer manager: controller, lookup and a row of buffer cells.
// Get: an execute state, then a finish state that may take the next request and registers the
// result beat. Mark dirty and empty: the execute state. Save all and flush: one buffer visited
// per cycle by the sweep counter, one beat at most per cycle. The output register is never
// stalled. Synchronous active-low reset unassigns every buffer, clears the dirty flags, restores
// the recency list to buffer order and leaves no current buffer; the block is ready at once.
`timescale 1ns / 1ps

module lru_block_buffer_manager_unit #(
  parameter int NUM_BUFFERS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lbbm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output lbbm_pkg::out_item_t  out_data
);

  localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CW = $clog2(NUM_BUFFERS + 1);
  localparam logic [CW-1:0] NoBuffer = CW'(NUM_BUFFERS);

  // Index widened or cut to the 3-bit result field.
  function automatic logic [2:0] idx3(input logic [IW-1:0] v);
    logic [IW+2:0] w;
    w = {3'b000, v};
    return w[2:0];
  endfunction

  lbbm_pkg::state_t    state_r, state_nxt;
  lbbm_pkg::in_item_t  in_r, in_nxt;
  logic [IW-1:0]       chosen_r, chosen_nxt;
  logic                found_r, found_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       current_r, current_nxt;
  logic                out_valid_r, out_valid_nxt;
  lbbm_pkg::out_item_t out_r, out_nxt;

  lbbm_pkg::cell_cmd_t cmd;
  logic [IW-1:0]       sel;
  logic [31:0]         tag_w   [NUM_BUFFERS];
  logic                dirty_w [NUM_BUFFERS];
  logic [IW-1:0]       rec_w   [NUM_BUFFERS];
  logic [NUM_BUFFERS:0] shift_w;

  logic          accept, fin;
  logic [IW-1:0] hit_idx, free_idx, victim, pick, rd_idx;
  logic          hit_any, free_any;
  logic [31:0]   rd_tag;
  logic          rd_dirty;

  // Row of buffer cells; the move-to-front shift travels from the back towards the front.
  assign shift_w[NUM_BUFFERS] = 1'b0;

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    logic [IW-1:0] prev;
    if (g == 0) begin : g_front
      assign prev = sel;
    end else begin : g_rest
      assign prev = rec_w[g-1];
    end
    lbbm_cell #(.IDX_W(IW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .pos       (IW'(g)),
      .cmd       (cmd),
      .sel       (sel),
      .prev_rec  (prev),
      .shift_in  (shift_w[g+1]),
      .tag       (tag_w[g]),
      .dirty     (dirty_w[g]),
      .rec       (rec_w[g]),
      .shift_out (shift_w[g])
    );
  end

  // Parallel tag compare: lowest matching buffer and highest unassigned buffer.
  always_comb begin
    hit_idx  = '0;
    hit_any  = 1'b0;
    free_idx = '0;
    free_any = 1'b0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (tag_w[i] == in_r.block_number) begin
        hit_idx = IW'(i);
        hit_any = 1'b1;
      end
    end
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (tag_w[i] == lbbm_pkg::UNASSIGNED_TAG) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  // On a miss take a free buffer, otherwise the one at the back of the recency list.
  assign victim = free_any ? free_idx : rec_w[NUM_BUFFERS-1];
  assign pick   = hit_any ? hit_idx : victim;

  // Single read port into the row.
  always_comb begin
    if (state_r == lbbm_pkg::ST_SWEEP) begin
      rd_idx = idx_r[IW-1:0];
    end else if (in_r.action == lbbm_pkg::ACT_MARK_DIRTY) begin
      rd_idx = current_r[IW-1:0];
    end else begin
      rd_idx = pick;
    end
  end

  assign rd_tag   = tag_w[rd_idx];
  assign rd_dirty = dirty_w[rd_idx];

  // Cycles in which the current item finishes and a new one may be taken.
  always_comb begin
    case (state_r)
      lbbm_pkg::ST_EXEC: begin
        fin = (in_r.action != lbbm_pkg::ACT_GET_READ) &&
              (in_r.action != lbbm_pkg::ACT_GET_NO_READ) &&
              (in_r.action != lbbm_pkg::ACT_SAVE_ALL) &&
              (in_r.action != lbbm_pkg::ACT_FLUSH);
      end
      lbbm_pkg::ST_GET_FIN: fin = 1'b1;
      lbbm_pkg::ST_SWEEP:   fin = (idx_r == NoBuffer);
      default:              fin = 1'b0;
    endcase
  end

  assign busy   = !((state_r == lbbm_pkg::ST_IDLE) || fin);
  assign accept = start && !busy;
  assign in_nxt = accept ? in_data : in_r;

  // Controller: next state, cell command and result beat.
  always_comb begin
    state_nxt     = state_r;
    chosen_nxt    = chosen_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    current_nxt   = current_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    cmd.op        = lbbm_pkg::CELL_NOP;
    cmd.write_tag = 1'b0;
    cmd.blk       = in_r.block_number;
    sel           = rd_idx;

    case (state_r)
      lbbm_pkg::ST_IDLE: begin
      end

      lbbm_pkg::ST_EXEC: begin
        case (in_r.action)
          lbbm_pkg::ACT_GET_READ, lbbm_pkg::ACT_GET_NO_READ: begin
            chosen_nxt = pick;
            found_nxt  = hit_any;
            // A dirty assigned victim is written back first.
            if (!hit_any && rd_dirty && (rd_tag != lbbm_pkg::UNASSIGNED_TAG)) begin
              out_valid_nxt           = 1'b1;
              out_nxt.kind            = lbbm_pkg::KIND_WRITE_BACK;
              out_nxt.buffer_index    = idx3(pick);
              out_nxt.block_of_buffer = rd_tag;
              cmd.op                  = lbbm_pkg::CELL_CLEAN;
            end
            state_nxt = lbbm_pkg::ST_GET_FIN;
          end
          lbbm_pkg::ACT_MARK_DIRTY: begin
            out_valid_nxt = 1'b1;
            out_nxt.last  = 1'b1;
            if (current_r >= NoBuffer) begin
              out_nxt.kind = lbbm_pkg::KIND_ERROR;
            end else begin
              out_nxt.kind            = lbbm_pkg::KIND_DONE;
              out_nxt.buffer_index    = idx3(current_r[IW-1:0]);
              out_nxt.block_of_buffer = rd_tag;
              cmd.op                  = lbbm_pkg::CELL_MARK;
            end
          end
          lbbm_pkg::ACT_SAVE_ALL, lbbm_pkg::ACT_FLUSH: begin
            idx_nxt   = '0;
            state_nxt = lbbm_pkg::ST_SWEEP;
          end
          lbbm_pkg::ACT_EMPTY: begin
            cmd.op        = lbbm_pkg::CELL_RESET;
            current_nxt   = NoBuffer;
            out_valid_nxt = 1'b1;
            out_nxt.kind  = lbbm_pkg::KIND_DONE;
            out_nxt.last  = 1'b1;
          end
          default: begin
          end
        endcase
      end

      // Install the block, move the buffer to the front and report it.
      lbbm_pkg::ST_GET_FIN: begin
        sel                     = chosen_r;
        cmd.op                  = lbbm_pkg::CELL_ASSIGN;
        cmd.write_tag           = !found_r;
        current_nxt             = CW'(chosen_r);
        out_valid_nxt           = 1'b1;
        out_nxt.kind            = lbbm_pkg::KIND_ASSIGNED;
        out_nxt.buffer_index    = idx3(chosen_r);
        out_nxt.block_of_buffer = in_r.block_number;
        out_nxt.hit             = found_r;
        out_nxt.fill_request    = !found_r && (in_r.action == lbbm_pkg::ACT_GET_READ);
        out_nxt.last            = 1'b1;
      end

      // Visit one buffer per cycle in ascending order, then report done; a flush unassigns all.
      lbbm_pkg::ST_SWEEP: begin
        if (idx_r != NoBuffer) begin
          if (rd_dirty && (rd_tag != lbbm_pkg::UNASSIGNED_TAG)) begin
            out_valid_nxt           = 1'b1;
            out_nxt.kind            = lbbm_pkg::KIND_WRITE_BACK;
            out_nxt.buffer_index    = idx3(rd_idx);
            out_nxt.block_of_buffer = rd_tag;
            cmd.op                  = lbbm_pkg::CELL_CLEAN;
          end
          idx_nxt = idx_r + CW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt.kind  = lbbm_pkg::KIND_DONE;
          out_nxt.last  = 1'b1;
          if (in_r.action == lbbm_pkg::ACT_FLUSH) begin
            cmd.op      = lbbm_pkg::CELL_UNASSIGN;
            current_nxt = NoBuffer;
          end
        end
      end

      default: begin
        state_nxt = lbbm_pkg::ST_IDLE;
      end
    endcase

    if (accept) begin
      state_nxt = lbbm_pkg::ST_EXEC;
    end else if (fin) begin
      state_nxt = lbbm_pkg::ST_IDLE;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbbm_pkg::ST_IDLE;
      chosen_r    <= '0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      current_r   <= NoBuffer;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chosen_r    <= chosen_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
      current_r   <= current_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> design/lbbm_checker.sv
// Port-level checks for the LRU block buffer manager, bound to its top level.
// Depends on lbbm_pkg and on lru_block_buffer_manager_unit for the bind.
`timescale 1ns / 1ps

module lbbm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input lbbm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input lbbm_pkg::out_item_t out_data
);

  // Reset leaves the block ready and with no beat pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // A get ends with one assigned beat, after its execute and finish states.
  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && ((in_data.action == lbbm_pkg::ACT_GET_READ) ||
                       (in_data.action == lbbm_pkg::ACT_GET_NO_READ))
    |=> ##2 out_valid && out_data.last && (out_data.kind == lbbm_pkg::KIND_ASSIGNED))
    else $error("get did not end with an assigned beat");

  // Mark dirty gives a single final done or error beat.
  a_mark_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.action == lbbm_pkg::ACT_MARK_DIRTY)
    |=> ##1 out_valid && out_data.last &&
            ((out_data.kind == lbbm_pkg::KIND_DONE) || (out_data.kind == lbbm_pkg::KIND_ERROR)))
    else $error("mark dirty gave no final beat");

  // An undefined action gives no beat.
  a_undefined_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.action > lbbm_pkg::ACT_EMPTY) |=> ##1 !out_valid)
    else $error("undefined action produced a beat");

  // Only write-back beats leave the sequence open, and only assigned beats carry hit or fill.
  a_beat_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.kind == lbbm_pkg::KIND_WRITE_BACK) != out_data.last) &&
                  ((out_data.kind == lbbm_pkg::KIND_ASSIGNED) ||
                   (!out_data.hit && !out_data.fill_request)))
    else $error("inconsistent result beat fields");

endmodule

bind lru_block_buffer_manager_unit lbbm_checker u_lbbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

>>> dv/lbbm_result_checker.sv
// Result checker for the LRU block buffer manager: watches the request and result beats,
// predicts every result from its own copy of the buffer state and compares them in order.
// Depends on lbbm_pkg for the beat structs and the action and result codes.
`timescale 1ns / 1ps

module lbbm_result_checker #(
  parameter int NUM_BUFFERS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  lbbm_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  lbbm_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_beats,
  output int                  beats_checked
);

  import lbbm_pkg::*;

  // Predicted buffer state: tags, dirty flags, recency list (front is newest) and current buffer.
  logic [31:0] buf_tag   [NUM_BUFFERS];
  logic        buf_dirty [NUM_BUFFERS];
  int unsigned recency   [NUM_BUFFERS];
  int unsigned cur_buf;

  // Result beats predicted but not yet seen, oldest first.
  out_item_t expected_beats[$];

  function automatic out_item_t make_beat(kind_t kind, int unsigned idx, logic [31:0] blk,
                                          logic hit, logic fill, logic last);
    out_item_t b;
    b.kind            = kind;
    b.buffer_index    = idx[2:0];
    b.block_of_buffer = blk;
    b.hit             = hit;
    b.fill_request    = fill;
    b.last            = last;
    return b;
  endfunction

  function automatic void clear_buffers();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      buf_tag[i]   = UNASSIGNED_TAG;
      buf_dirty[i] = 1'b0;
      recency[i]   = i;
    end
    cur_buf = NUM_BUFFERS;
  endfunction

  // Save all, flush: one write-back per dirty assigned buffer in order, then done; flush unassigns.
  function automatic void sweep_dirty(bit unassign);
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      if (buf_dirty[i] && buf_tag[i] != UNASSIGNED_TAG) begin
        expected_beats.push_back(make_beat(KIND_WRITE_BACK, i, buf_tag[i], 1'b0, 1'b0, 1'b0));
        buf_dirty[i] = 1'b0;
      end
      if (unassign) buf_tag[i] = UNASSIGNED_TAG;
    end
    if (unassign) cur_buf = NUM_BUFFERS;
    expected_beats.push_back(make_beat(KIND_DONE, 0, '0, 1'b0, 1'b0, 1'b1));
  endfunction

  // Works out the result beats of one accepted request and updates the predicted state.
  function automatic void predict_request(in_item_t req);
    bit          found;
    int unsigned chosen;
    int unsigned free_buf;
    int unsigned pos;
    logic [31:0] blk;
    blk = req.block_number;
    case (req.action)
      ACT_GET_READ, ACT_GET_NO_READ: begin
        found    = 1'b0;
        chosen   = 0;
        free_buf = NUM_BUFFERS;
        // The scan stops at the first match; an all-ones block matches the first free buffer.
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if (!found) begin
            if (buf_tag[i] == blk) begin
              chosen = i;
              found  = 1'b1;
            end else if (buf_tag[i] == UNASSIGNED_TAG) begin
              free_buf = i;
            end
          end
        end
        if (!found) begin
          chosen = (free_buf < NUM_BUFFERS) ? free_buf : recency[NUM_BUFFERS-1];
          if (chosen >= NUM_BUFFERS) chosen = 0;
          if (buf_dirty[chosen] && buf_tag[chosen] != UNASSIGNED_TAG) begin
            expected_beats.push_back(make_beat(KIND_WRITE_BACK, chosen, buf_tag[chosen],
                                               1'b0, 1'b0, 1'b0));
            buf_dirty[chosen] = 1'b0;
          end
          buf_tag[chosen] = blk;
        end
        cur_buf = chosen;
        // Move the chosen buffer to the front of the recency list.
        pos = 0;
        for (int i = 0; i < NUM_BUFFERS; i++) begin
          if (recency[i] == chosen) pos = i;
        end
        for (int j = pos; j > 0; j--) recency[j] = recency[j-1];
        recency[0] = chosen;
        expected_beats.push_back(make_beat(KIND_ASSIGNED, chosen, blk, found,
                                           !found && req.action == ACT_GET_READ, 1'b1));
      end
      ACT_MARK_DIRTY: begin
        if (cur_buf >= NUM_BUFFERS) begin
          expected_beats.push_back(make_beat(KIND_ERROR, 0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          buf_dirty[cur_buf] = 1'b1;
          expected_beats.push_back(make_beat(KIND_DONE, cur_buf, buf_tag[cur_buf],
                                             1'b0, 1'b0, 1'b1));
        end
      end
      ACT_SAVE_ALL: sweep_dirty(1'b0);
      ACT_FLUSH:    sweep_dirty(1'b1);
      ACT_EMPTY: begin
        clear_buffers();
        expected_beats.push_back(make_beat(KIND_DONE, 0, '0, 1'b0, 1'b0, 1'b1));
      end
      default: begin
        // Reserved actions leave the state alone and give no beat.
      end
    endcase
  endfunction

  function automatic void note_failure(string what, out_item_t exp_b, out_item_t got_b);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind=%0d idx=%0d blk=%h hit=%0b fill=%0b last=%0b",
               exp_b.kind, exp_b.buffer_index, exp_b.block_of_buffer,
               exp_b.hit, exp_b.fill_request, exp_b.last);
      $display("  actual   kind=%0d idx=%0d blk=%h hit=%0b fill=%0b last=%0b",
               got_b.kind, got_b.buffer_index, got_b.block_of_buffer,
               got_b.hit, got_b.fill_request, got_b.last);
    end
    fail_count++;
  endfunction

  initial begin
    fail_count    = 0;
    pending_beats = 0;
    beats_checked = 0;
    clear_buffers();
  end

  // Requests are predicted before results are compared, so a beat never overtakes its request.
  always @(posedge clk) begin
    out_item_t exp_b;
    if (!rst_n) begin
      clear_buffers();
      expected_beats.delete();
    end else begin
      if (start && !busy) predict_request(in_data);
      if (out_valid) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          note_failure("result beat with nothing expected", '0, out_data);
        end else begin
          exp_b = expected_beats.pop_front();
          if (out_data.kind !== exp_b.kind ||
              out_data.buffer_index !== exp_b.buffer_index ||
              out_data.block_of_buffer !== exp_b.block_of_buffer ||
              out_data.hit !== exp_b.hit ||
              out_data.fill_request !== exp_b.fill_request ||
              out_data.last !== exp_b.last)
            note_failure("result beat mismatch", exp_b, out_data);
        end
      end
    end
    pending_beats = expected_beats.size();
  end

endmodule

>>> dv/lru_block_buffer_manager_unit_tb.sv
// Testbench top for the LRU block buffer manager: clock, reset, request stimulus and verdict.
// Depends on lbbm_pkg, the block lru_block_buffer_manager_unit and lbbm_result_checker.
`timescale 1ns / 1ps

module lru_block_buffer_manager_unit_tb;

  import lbbm_pkg::*;

  localparam int NUM_BUFFERS = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int POOL_SIZE   = 12;
  localparam logic [2:0] ACT_RESERVED_A = 3'd6;
  localparam logic [2:0] ACT_RESERVED_B = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int pending_beats;
  int beats_checked;
  int requests_sent;
  int sender_idle_pct;
  int stall_cycles;

  // Small set of block numbers so that gets hit, fill and evict often.
  logic [31:0] block_pool [POOL_SIZE];

  lru_block_buffer_manager_unit #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  lbbm_result_checker #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_beats(pending_beats),
    .beats_checked(beats_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: too many cycles in a row without a request or a result beat ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one request from a falling edge and holds it until the block takes it.
  task automatic send_request(input logic [2:0] act, input logic [31:0] blk);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start                = 1'b1;
    in_data.action       = act;
    in_data.block_number = blk;
    do @(posedge clk); while (busy);
    @(negedge clk);
    requests_sent++;
  endtask

  // Holds off new requests until every predicted beat has arrived.
  task automatic wait_for_drain();
    start = 1'b0;
    while (pending_beats != 0) @(negedge clk);
  endtask

  // Mostly gets and dirty marks on pooled blocks, with sweeps, empties and odd requests mixed in.
  task automatic send_random(input int count);
    int          counted;
    int          roll;
    logic [2:0]  act;
    logic [31:0] blk;
    counted = 0;
    while (counted < count) begin
      roll = $urandom_range(99);
      blk  = ($urandom_range(9) < 8) ? block_pool[$urandom_range(POOL_SIZE-1)] : $urandom();
      if (roll < 32)      act = ACT_GET_READ;
      else if (roll < 52) act = ACT_GET_NO_READ;
      else if (roll < 72) act = ACT_MARK_DIRTY;
      else if (roll < 80) act = ACT_SAVE_ALL;
      else if (roll < 83) act = ACT_FLUSH;
      else if (roll < 86) act = ACT_EMPTY;
      else if (roll < 90) act = $urandom_range(1) ? ACT_RESERVED_A : ACT_RESERVED_B;
      else if (roll < 95) begin
        act = ACT_GET_READ;
        blk = UNASSIGNED_TAG;
      end else begin
        act = ACT_GET_NO_READ;
        blk = $urandom();
      end
      send_request(act, blk);
      if (act <= ACT_EMPTY) counted++;
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_data         = '0;
    requests_sent   = 0;
    sender_idle_pct = 0;
    stall_cycles    = 0;
    for (int i = 0; i < POOL_SIZE; i++) block_pool[i] = $urandom();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: no current buffer, field extremes, the all-ones block and reserved codes.
    send_request(ACT_MARK_DIRTY,  32'h0000_0000);
    send_request(ACT_SAVE_ALL,    32'hFFFF_FFFF);
    send_request(ACT_GET_READ,    32'h0000_0000);
    send_request(ACT_GET_READ,    32'h0000_0000);
    send_request(ACT_MARK_DIRTY,  32'hFFFF_FFFF);
    send_request(ACT_GET_NO_READ, 32'hFFFF_FFFE);
    send_request(ACT_GET_READ,    UNASSIGNED_TAG);
    send_request(ACT_MARK_DIRTY,  32'h0000_0000);
    send_request(ACT_SAVE_ALL,    32'h0000_0000);
    send_request(ACT_GET_READ,    32'hA5A5_A5A5);
    send_request(ACT_GET_NO_READ, 32'h5A5A_5A5A);
    send_request(ACT_MARK_DIRTY,  32'h0000_0000);
    send_request(ACT_GET_READ,    32'h1234_5678);
    send_request(ACT_GET_READ,    32'h8000_0000);
    send_request(ACT_GET_NO_READ, 32'h0000_0001);
    // The dirty but unassigned buffer is reused here without a write-back.
    send_request(ACT_GET_READ,    32'h7FFF_FFFF);
    send_request(ACT_MARK_DIRTY,  32'h0000_0000);
    // All buffers are assigned now, so these evict the least recently used ones.
    send_request(ACT_GET_READ,    32'hDEAD_BEEF);
    send_request(ACT_GET_NO_READ, 32'h0000_0000);
    send_request(ACT_RESERVED_A,  32'hFFFF_FFFF);
    send_request(ACT_RESERVED_B,  32'h0000_0000);
    send_request(ACT_FLUSH,       32'h0000_0000);
    send_request(ACT_MARK_DIRTY,  32'h0000_0000);
    send_request(ACT_EMPTY,       32'hFFFF_FFFF);
    wait_for_drain();

    // Random part in three phases of sender idling, draining between phases.
    sender_idle_pct = 11;
    send_random(40);
    wait_for_drain();
    for (int i = 0; i < POOL_SIZE; i++) block_pool[i] = $urandom();
    sender_idle_pct = 65;
    send_random(40);
    wait_for_drain();
    sender_idle_pct = 0;
    send_random(40);

    wait_for_drain();
    repeat (NUM_BUFFERS + 6) @(negedge clk);
    $display("Covered %0d requests (gets, dirty marks, sweeps, empties, reserved codes)",
             requests_sent);
    $display("under three sender idling mixes; %0d result beats compared.", beats_checked);
    if (fail_count == 0 && pending_beats == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
design/lbbm_pkg.sv
design/lbbm_cell.sv
design/lru_block_buffer_manager_unit.sv
design/lbbm_checker.sv
dv/lbbm_result_checker.sv
dv/lru_block_buffer_manager_unit_tb.sv
